// ===== src/hex_addr_value_command_parser_assert.svh =====
// Assertion macros used by the parser's top-level RTL file.
// Each macro takes a label, a clock, an active-low reset, the two sides of
// the property and a message string.
`ifndef HEX_ADDR_VALUE_COMMAND_PARSER_ASSERT_SVH
`define HEX_ADDR_VALUE_COMMAND_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HAV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HAV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hav_pkg.sv =====
`default_nettype none

package hav_pkg;

    // Default digit limits of the two fields.
    localparam int ADDR_DIGITS_DEF = 8;
    localparam int VAL_DIGITS_DEF  = 8;

    // ASCII codes of the hex digit ranges.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;

    // Result status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ADDR_LONG   = 3'd1;
    localparam logic [2:0] ST_VAL_LONG    = 3'd2;
    localparam logic [2:0] ST_ADDR_LEN    = 3'd3;
    localparam logic [2:0] ST_VAL_MISSING = 3'd4;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } in_t;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] data_value;
        logic [3:0]  value_digits;
        logic [2:0]  parse_status;
    } out_t;

    // A finished line leaving the parser for the result register.
    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } nib_t;

    function automatic nib_t hex_nibble(input logic [7:0] c);
        nib_t n;
        logic [7:0] d;
        n = '{is_hex: 1'b0, value: 4'd0};
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            n = '{is_hex: 1'b1, value: d[3:0]};
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = c - CH_UP_A + 8'd10;
            n = '{is_hex: 1'b1, value: d[3:0]};
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d = c - CH_LO_A + 8'd10;
            n = '{is_hex: 1'b1, value: d[3:0]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/hav_parse.sv =====
`default_nettype none

module hav_parse #(
    parameter int ADDR_DIGITS = hav_pkg::ADDR_DIGITS_DEF,
    parameter int VAL_DIGITS  = hav_pkg::VAL_DIGITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire hav_pkg::in_t beat,
    output hav_pkg::res_t    res
);
    import hav_pkg::*;

    localparam int ACNT_W = $clog2(ADDR_DIGITS + 1);
    localparam int VCNT_W = $clog2(VAL_DIGITS + 1);
    localparam logic [ACNT_W-1:0] ADDR_MAX = ACNT_W'(ADDR_DIGITS);
    localparam logic [VCNT_W-1:0] VAL_MAX  = VCNT_W'(VAL_DIGITS);

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_ADDR_LONG = 2'd1;
    localparam logic [1:0] ERR_VAL_LONG  = 2'd2;

    typedef enum logic [1:0] {PH_SEEK, PH_ADDR, PH_VAL, PH_DONE} phase_t;

    phase_t            phase_reg, phase_next, phase_upd;
    logic [ACNT_W-1:0] addr_cnt_reg, addr_cnt_next, addr_cnt_upd;
    logic [VCNT_W-1:0] val_cnt_reg, val_cnt_next, val_cnt_upd;
    logic [31:0]       addr_acc_reg, addr_acc_next, addr_acc_upd;
    logic [31:0]       val_acc_reg, val_acc_next, val_acc_upd;
    logic [1:0]        err_reg, err_next, err_upd;
    logic [2:0]        status;
    nib_t              nib;

    assign nib = hex_nibble(beat.char_in);

    // Effect of one byte on the parser state.
    always_comb begin
        phase_upd    = phase_reg;
        addr_cnt_upd = addr_cnt_reg;
        val_cnt_upd  = val_cnt_reg;
        addr_acc_upd = addr_acc_reg;
        val_acc_upd  = val_acc_reg;
        err_upd      = err_reg;
        unique case (phase_reg)
            PH_SEEK, PH_ADDR: begin
                if (nib.is_hex) begin
                    if (addr_cnt_reg >= ADDR_MAX) begin
                        err_upd   = ERR_ADDR_LONG;
                        phase_upd = PH_DONE;
                    end else begin
                        phase_upd    = PH_ADDR;
                        addr_acc_upd = {addr_acc_reg[27:0], nib.value};
                        addr_cnt_upd = addr_cnt_reg + 1'b1;
                    end
                end else if (phase_reg == PH_ADDR) begin
                    phase_upd = PH_VAL;
                end
            end
            PH_VAL: begin
                if (nib.is_hex) begin
                    if (val_cnt_reg >= VAL_MAX) begin
                        err_upd   = ERR_VAL_LONG;
                        phase_upd = PH_DONE;
                    end else begin
                        val_acc_upd = {val_acc_reg[27:0], nib.value};
                        val_cnt_upd = val_cnt_reg + 1'b1;
                    end
                end else if (val_cnt_reg != '0) begin
                    phase_upd = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Status in priority order: overflow errors, address length, missing value.
    always_comb begin
        if (err_upd == ERR_ADDR_LONG) begin
            status = ST_ADDR_LONG;
        end else if (err_upd == ERR_VAL_LONG) begin
            status = ST_VAL_LONG;
        end else if (addr_cnt_upd != ADDR_MAX) begin
            status = ST_ADDR_LEN;
        end else if (val_cnt_upd == '0) begin
            status = ST_VAL_MISSING;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        res.valid             = step && beat.end_of_line;
        res.data.address      = addr_acc_upd;
        res.data.data_value   = val_acc_upd;
        res.data.value_digits = 4'(val_cnt_upd);
        res.data.parse_status = status;
    end

    // A line end returns everything to the reset state.
    always_comb begin
        phase_next    = phase_reg;
        addr_cnt_next = addr_cnt_reg;
        val_cnt_next  = val_cnt_reg;
        addr_acc_next = addr_acc_reg;
        val_acc_next  = val_acc_reg;
        err_next      = err_reg;
        if (step) begin
            if (beat.end_of_line) begin
                phase_next    = PH_SEEK;
                addr_cnt_next = '0;
                val_cnt_next  = '0;
                addr_acc_next = '0;
                val_acc_next  = '0;
                err_next      = ERR_NONE;
            end else begin
                phase_next    = phase_upd;
                addr_cnt_next = addr_cnt_upd;
                val_cnt_next  = val_cnt_upd;
                addr_acc_next = addr_acc_upd;
                val_acc_next  = val_acc_upd;
                err_next      = err_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg    <= PH_SEEK;
            addr_cnt_reg <= '0;
            val_cnt_reg  <= '0;
            addr_acc_reg <= '0;
            val_acc_reg  <= '0;
            err_reg      <= ERR_NONE;
        end else begin
            phase_reg    <= phase_next;
            addr_cnt_reg <= addr_cnt_next;
            val_cnt_reg  <= val_cnt_next;
            addr_acc_reg <= addr_acc_next;
            val_acc_reg  <= val_acc_next;
            err_reg      <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/hav_out_reg.sv =====
`default_nettype none

module hav_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hav_pkg::res_t res,
    input  wire logic          stall,
    output logic               free,
    output logic               valid,
    output hav_pkg::out_t      data
);
    import hav_pkg::*;

    logic valid_reg, valid_next;
    out_t data_reg, data_next;

    // The register may take a new result when empty or when its beat leaves.
    assign free = !valid_reg || !stall;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (free) begin
            valid_next = res.valid;
            if (res.valid) begin
                data_next = res.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

// ===== src/hex_addr_value_command_parser.sv =====
// Channel   Direction  Handshake                   Payload
// char      in         char_valid / char_stall     char_data   (hav_pkg::in_t)
// result    out        result_valid / result_stall result_data (hav_pkg::out_t)
//
// Every byte beat is first held in an input register; the parser updates its
// state from that register, so a byte enters every cycle unless char_stall is high.
// A result is written to the result register at the clock edge on which the
// parser takes its line-end byte, because the parser works on that byte while it
// sits in the input register; a line end passes the input register, then the result register.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to seeking an address; no clearing pass is needed.
// A stalled result only holds back a line-end byte waiting in the input
// register; other bytes keep flowing while the result waits, until such a byte arrives there.
`default_nettype none
`include "hex_addr_value_command_parser_assert.svh"

module hex_addr_value_command_parser #(
    parameter int ADDR_DIGITS = hav_pkg::ADDR_DIGITS_DEF,
    parameter int VAL_DIGITS  = hav_pkg::VAL_DIGITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         char_valid,
    output logic              char_stall,
    input  wire hav_pkg::in_t char_data,
    output logic              result_valid,
    input  wire logic         result_stall,
    output hav_pkg::out_t     result_data
);
    import hav_pkg::*;

    // Input register: one byte beat waiting for the parser.
    logic in_valid_reg, in_valid_next;
    in_t  in_data_reg, in_data_next;

    logic out_free;
    logic consume;
    res_t res;

    // A byte that ends a line needs room in the result register; any other
    // byte is always taken by the parser.
    assign consume    = in_valid_reg && (!in_data_reg.end_of_line || out_free);
    assign char_stall = in_valid_reg && !consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (!char_stall) begin
            in_valid_next = char_valid;
            if (char_valid) begin
                in_data_next = char_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        in_data_reg <= in_data_next;
    end

    hav_parse #(
        .ADDR_DIGITS (ADDR_DIGITS),
        .VAL_DIGITS  (VAL_DIGITS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (consume),
        .beat  (in_data_reg),
        .res   (res)
    );

    hav_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .stall (result_stall),
        .free  (out_free),
        .valid (result_valid),
        .data  (result_data)
    );

    // Only a line-end byte facing a full, stalled result register blocks input.
    `HAV_ASSERT_SAME(a_stall_cause, clk, rst_n, char_stall,
        in_valid_reg && in_data_reg.end_of_line && result_valid && result_stall,
        "input stalled without a blocked line end")

    // A line end taken by the parser gives a result in the next cycle.
    `HAV_ASSERT_NEXT(a_line_result, clk, rst_n, consume && in_data_reg.end_of_line,
        result_valid, "line end produced no result")

    // Status codes stay within the defined set.
    `HAV_ASSERT_SAME(a_status_range, clk, rst_n, result_valid,
        result_data.parse_status <= ST_VAL_MISSING, "undefined status code")

    // A good line always carries at least one value digit.
    `HAV_ASSERT_SAME(a_ok_has_value, clk, rst_n,
        result_valid && result_data.parse_status == ST_OK,
        result_data.value_digits != 4'd0, "ok status without value digits")

endmodule

`default_nettype wire
